### rtl/bdc_pkg.sv
// shared types and constants for the cubic bezier point evaluator
package bdc_pkg;

  localparam int COORD_W   = 10;
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int FX_W      = COORD_W + FRAC_BITS;
  localparam int CIDX_W    = 8;
  localparam int FRAME_W_W = 13;

  // t on the input port is always Q1.16, rescaled to FRAC_BITS inside
  localparam int T_IN_FRAC = 16;
  localparam int T_IN_W    = T_IN_FRAC + 1;

  localparam logic [T_W-1:0]       T_ONE        = T_W'(1) << FRAC_BITS;
  localparam logic [T_IN_W-1:0]    T_IN_ONE     = T_IN_W'(1) << T_IN_FRAC;
  localparam logic [FRAME_W_W-1:0] FRAME_WIDTH  = FRAME_W_W'(1024);
  localparam logic [FRAME_W_W-1:0] FRAME_HEIGHT = FRAME_W_W'(1024);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_P0_X = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_P0_Y = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_P1_X = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_P1_Y = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_P2_X = CIDX_W'(4);
  localparam logic [CIDX_W-1:0] REG_P2_Y = CIDX_W'(5);
  localparam logic [CIDX_W-1:0] REG_P3_X = CIDX_W'(6);
  localparam logic [CIDX_W-1:0] REG_P3_Y = CIDX_W'(7);

  // status of one pipeline level
  typedef struct packed {
    logic valid;
    logic load;
  } bdc_stg_t;

endpackage

### rtl/bezier_de_casteljau_point.sv
// cubic bezier point evaluator, de casteljau lerp pipeline
//
// usage:
//   control points p0..p3 (x,y, 10 bit pixels) are written on the config
//   channel, index 0..7 in the order p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y;
//   other indexes are dropped. cfg_ready_o is always high. write only while
//   no word is in flight.
//   input channel: one word carries t_param (unsigned Q1.16, 65536 = 1.0,
//   larger values clamp to 1.0).
//   output channel: pixel_x, pixel_y (truncated) and plot (inside frame).
// timing:
//   three lerp levels, one register each; the third level is the output
//   register. words pass levels one, two, three in order; one word per cycle
//   sustained unless the output stalls; each level is one multiplier per cell.
// stall:
//   a level holds its word while the next level is full and not moving, so
//   bubbles close up and input keeps flowing until all three levels are full.
// reset:
//   all levels empty, control points cleared to zero.
module bezier_de_casteljau_point (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bdc_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [bdc_pkg::COORD_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdc_pkg::T_IN_W-1:0]    t_param_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdc_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [bdc_pkg::COORD_W-1:0]   pixel_y_o,
  output logic                          plot_o
);

  localparam int FX = bdc_pkg::FX_W;
  localparam int CW = bdc_pkg::COORD_W;
  localparam int FB = bdc_pkg::FRAC_BITS;

  // control point registers
  logic [CW-1:0] cx_q [4];
  logic [CW-1:0] cy_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdc_pkg::REG_P0_X: cx_q[0] <= cfg_data_i;
        bdc_pkg::REG_P0_Y: cy_q[0] <= cfg_data_i;
        bdc_pkg::REG_P1_X: cx_q[1] <= cfg_data_i;
        bdc_pkg::REG_P1_Y: cy_q[1] <= cfg_data_i;
        bdc_pkg::REG_P2_X: cx_q[2] <= cfg_data_i;
        bdc_pkg::REG_P2_Y: cy_q[2] <= cfg_data_i;
        bdc_pkg::REG_P3_X: cx_q[3] <= cfg_data_i;
        bdc_pkg::REG_P3_Y: cy_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp t to 1.0, then move it from Q1.16 to the internal fraction
  logic [bdc_pkg::T_IN_W-1:0] t_in_sat;
  logic [bdc_pkg::T_W-1:0]    t_sat;
  assign t_in_sat = (t_param_i > bdc_pkg::T_IN_ONE) ? bdc_pkg::T_IN_ONE : t_param_i;

  if (FB >= bdc_pkg::T_IN_FRAC) begin : g_t_up
    assign t_sat = bdc_pkg::T_W'(t_in_sat) << (FB - bdc_pkg::T_IN_FRAC);
  end else begin : g_t_down
    assign t_sat = bdc_pkg::T_W'(t_in_sat >> (bdc_pkg::T_IN_FRAC - FB));
  end

  // level handshakes
  bdc_pkg::bdc_stg_t stg1, stg2, stg3;
  logic rdy1, rdy2, rdy3;

  bdc_stage_ctl u_ctl1 (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_i(rdy2), .ready_o(rdy1), .stg_o(stg1)
  );
  bdc_stage_ctl u_ctl2 (
    .clk_i, .rst_ni, .valid_i(stg1.valid), .ready_i(rdy3), .ready_o(rdy2), .stg_o(stg2)
  );
  bdc_stage_ctl u_ctl3 (
    .clk_i, .rst_ni, .valid_i(stg2.valid), .ready_i(out_ready_i), .ready_o(rdy3),
    .stg_o(stg3)
  );

  assign in_ready_o = rdy1;

  // t travels along with each level
  logic [bdc_pkg::T_W-1:0] t1_q, t2_q;

  always_ff @(posedge clk_i) begin
    if (stg1.load) begin
      t1_q <= t_sat;
    end
    if (stg2.load) begin
      t2_q <= t1_q;
    end
  end

  // control points as Q10.16
  logic [FX-1:0] ax [4];
  logic [FX-1:0] ay [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ax[i] = {cx_q[i], {FB{1'b0}}};
      ay[i] = {cy_q[i], {FB{1'b0}}};
    end
  end

  logic [FX-1:0] bx [3];
  logic [FX-1:0] by [3];
  logic [FX-1:0] dx [2];
  logic [FX-1:0] dy [2];
  logic [FX-1:0] ex, ey;

  // first level: three cells per axis
  for (genvar g = 0; g < 3; g++) begin : g_lvl1
    bdc_lerp_cell u_cx (
      .clk_i, .en_i(stg1.load), .a_i(ax[g]), .b_i(ax[g+1]), .t_i(t_sat), .q_o(bx[g])
    );
    bdc_lerp_cell u_cy (
      .clk_i, .en_i(stg1.load), .a_i(ay[g]), .b_i(ay[g+1]), .t_i(t_sat), .q_o(by[g])
    );
  end

  // second level: two cells per axis
  for (genvar g = 0; g < 2; g++) begin : g_lvl2
    bdc_lerp_cell u_cx (
      .clk_i, .en_i(stg2.load), .a_i(bx[g]), .b_i(bx[g+1]), .t_i(t1_q), .q_o(dx[g])
    );
    bdc_lerp_cell u_cy (
      .clk_i, .en_i(stg2.load), .a_i(by[g]), .b_i(by[g+1]), .t_i(t1_q), .q_o(dy[g])
    );
  end

  // last level, doubles as output register
  bdc_lerp_cell u_lvl3_x (
    .clk_i, .en_i(stg3.load), .a_i(dx[0]), .b_i(dx[1]), .t_i(t2_q), .q_o(ex)
  );
  bdc_lerp_cell u_lvl3_y (
    .clk_i, .en_i(stg3.load), .a_i(dy[0]), .b_i(dy[1]), .t_i(t2_q), .q_o(ey)
  );

  assign out_valid_o = stg3.valid;
  assign pixel_x_o   = ex[FX-1:FB];
  assign pixel_y_o   = ey[FX-1:FB];
  assign plot_o      = (bdc_pkg::FRAME_W_W'(pixel_x_o) < bdc_pkg::FRAME_WIDTH) &&
                       (bdc_pkg::FRAME_W_W'(pixel_y_o) < bdc_pkg::FRAME_HEIGHT);

`ifndef SYNTHESIS
  // full pipe with stalled output must refuse input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg1.valid && stg2.valid && stg3.valid && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipe full and stalled");

  // an accepted word lands in the first level
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> stg1.valid)
    else $error("accepted word lost at first level");

  // clamped t never exceeds one
  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg1.valid |-> (t1_q <= bdc_pkg::T_ONE))
    else $error("t above one in pipeline");

  // a word in level two moves on or stays, never vanishes
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg2.valid && !rdy3) |=> stg2.valid)
    else $error("stalled word dropped at level two");
`endif

endmodule

### rtl/bdc_lerp_cell.sv
// one fixed-point lerp cell with registered output
module bdc_lerp_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bdc_pkg::FX_W-1:0]  a_i,
  input  logic [bdc_pkg::FX_W-1:0]  b_i,
  input  logic [bdc_pkg::T_W-1:0]   t_i,
  output logic [bdc_pkg::FX_W-1:0]  q_o
);

  localparam int DW = bdc_pkg::FX_W + 1;
  localparam int PW = DW + bdc_pkg::T_W + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic [bdc_pkg::FX_W-1:0] q_d;
  logic [bdc_pkg::FX_W-1:0] q_q;

  // (1-t)*a + t*b == a*one + t*(b-a), floor shift keeps it exact
  assign diff = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
  assign prod = PW'(diff) * $signed({1'b0, t_i});
  assign sum  = $signed(PW'({1'b0, a_i})) + (prod >>> bdc_pkg::FRAC_BITS);
  assign q_d  = sum[bdc_pkg::FX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

### rtl/bdc_stage_ctl.sv
// valid bit and handshake of one pipeline level
module bdc_stage_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              ready_i,
  output logic              ready_o,
  output bdc_pkg::bdc_stg_t stg_o
);

  logic valid_d;
  logic valid_q;
  logic load;

  // a level takes a new word when empty or when its word moves on
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stg_o.valid = valid_q;
  assign stg_o.load  = load;

endmodule

### dv/bezier_de_casteljau_point_tb.sv
// self-checking testbench for the cubic bezier point evaluator
`timescale 1ns / 100ps

module bezier_de_casteljau_point_tb;
  import bdc_pkg::*;

  // quiet cycles (no word moved on any channel) before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // idle tail after the final drain; the three lerp levels are already empty by then
  localparam int DRAIN_CYCLES = 8;
  localparam int BLOCKS_PER_PHASE = 5;
  localparam int WORDS_PER_BLOCK = 126;
  localparam int HOLD_CYCLES = 80;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [T_IN_W-1:0] T_MAX = '1;
  // the input is always Q1.16, whatever the internal fraction width
  localparam logic [63:0] Q16_ONE = 64'd65536;

  // indexes that the block must drop
  localparam logic [CIDX_W-1:0] IDX_UNUSED_LO = CIDX_W'(8);
  localparam logic [CIDX_W-1:0] IDX_UNUSED_HI = '1;

  localparam logic [CIDX_W-1:0] REG_ORDER [8] = '{REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
                                                 REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               plot;
  } pixel_t;

  typedef enum logic {ROW_CFG, ROW_T} row_kind_e;

  // one directed step: a register write or a t word, with an optional typed-in result
  typedef struct packed {
    row_kind_e          kind;
    logic [CIDX_W-1:0]  idx;
    logic [COORD_W-1:0] data;
    logic [T_IN_W-1:0]  t;
    logic               typed;
    pixel_t             px;
  } dir_row_t;

  localparam int N_DIR = 33;

  // rows with typed = 0 are checked against the predictor
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // control points all zero after reset: every t lands on the origin
    '{ROW_T,   '0,            '0,        '0,          1'b1, '{'0, '0, 1'b1}},
    '{ROW_T,   '0,            '0,        T_IN_ONE,    1'b1, '{'0, '0, 1'b1}},
    '{ROW_T,   '0,            '0,        T_MAX,       1'b1, '{'0, '0, 1'b1}},
    // corner-to-corner curve, ends at (5, 1023)
    '{ROW_CFG, REG_P0_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P0_Y,      '0,        '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P1_X,      '0,        '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P1_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P2_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P2_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P3_X,      10'd5,     '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P3_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    // writes to unused indexes must leave the points alone
    '{ROW_CFG, IDX_UNUSED_LO, '0,        '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, IDX_UNUSED_HI, 10'h155,   '0,          1'b0, '{'0, '0, 1'b0}},
    // t = 0 gives p0 and t = 1.0 gives p3 exactly
    '{ROW_T,   '0,            '0,        '0,          1'b1, '{COORD_MAX, '0, 1'b1}},
    '{ROW_T,   '0,            '0,        T_IN_ONE,    1'b1, '{10'd5, COORD_MAX, 1'b1}},
    // t above one clamps to 1.0
    '{ROW_T,   '0,            '0,        T_IN_ONE + 1'b1, 1'b1, '{10'd5, COORD_MAX, 1'b1}},
    '{ROW_T,   '0,            '0,        T_MAX,       1'b1, '{10'd5, COORD_MAX, 1'b1}},
    '{ROW_T,   '0,            '0,        17'h15555,   1'b1, '{10'd5, COORD_MAX, 1'b1}},
    // interior points
    '{ROW_T,   '0,            '0,        17'd1,       1'b0, '{'0, '0, 1'b0}},
    '{ROW_T,   '0,            '0,        17'h08000,   1'b0, '{'0, '0, 1'b0}},
    '{ROW_T,   '0,            '0,        17'h0FFFF,   1'b0, '{'0, '0, 1'b0}},
    '{ROW_T,   '0,            '0,        17'h0AAAA,   1'b0, '{'0, '0, 1'b0}},
    '{ROW_T,   '0,            '0,        17'h05555,   1'b0, '{'0, '0, 1'b0}},
    // every point at the far corner: the curve collapses onto it
    '{ROW_CFG, REG_P0_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P0_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P1_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P1_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P2_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P2_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P3_X,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_CFG, REG_P3_Y,      COORD_MAX, '0,          1'b0, '{'0, '0, 1'b0}},
    '{ROW_T,   '0,            '0,        17'h0ABCD,   1'b1, '{COORD_MAX, COORD_MAX, 1'b1}},
    '{ROW_T,   '0,            '0,        '0,          1'b1, '{COORD_MAX, COORD_MAX, 1'b1}}
  };

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CIDX_W-1:0]  cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [T_IN_W-1:0]  t_param_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [COORD_W-1:0] pixel_x_o;
  logic [COORD_W-1:0] pixel_y_o;
  logic               plot_o;

  // predictor copy of the control points
  logic [COORD_W-1:0] ctrl_x [4];
  logic [COORD_W-1:0] ctrl_y [4];

  pixel_t pending_px [$];   // predicted pixels, oldest first
  int     mismatch_cnt = 0;
  int     quiet_cycles = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;
  int     hold_left = 0;
  logic   hold_req = 1'b0;

  bezier_de_casteljau_point i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .t_param_i  (t_param_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .plot_o     (plot_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- predictor

  // one fixed-point lerp, truncated
  function automatic logic [63:0] lerp_fx(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] t);
    return (((64'd1 << FRAC_BITS) - t) * a + t * b) >> FRAC_BITS;
  endfunction

  // de casteljau on one axis: 3, then 2, then 1 lerp; returns the untruncated pixel
  function automatic logic [63:0] eval_axis(input logic [COORD_W-1:0] c [4],
                                            input logic [63:0] t);
    logic [63:0] q [4];
    for (int i = 0; i < 4; i++) q[i] = 64'(c[i]) << FRAC_BITS;
    for (int lvl = 3; lvl > 0; lvl--) begin
      for (int i = 0; i < lvl; i++) q[i] = lerp_fx(q[i], q[i+1], t);
    end
    return q[0] >> FRAC_BITS;
  endfunction

  function automatic pixel_t predict_pixel(input logic [T_IN_W-1:0] t_raw);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] y;
    pixel_t      px;
    // clamp to 1.0 first, then rescale Q1.16 to the internal fraction
    t = (64'(t_raw) > Q16_ONE) ? Q16_ONE : 64'(t_raw);
    if (FRAC_BITS >= 16) t = t << (FRAC_BITS - 16);
    else t = t >> (16 - FRAC_BITS);
    x = eval_axis(ctrl_x, t);
    y = eval_axis(ctrl_y, t);
    px.x = COORD_W'(x);
    px.y = COORD_W'(y);
    px.plot = (x < 64'(FRAME_WIDTH)) && (y < 64'(FRAME_HEIGHT));
    return px;
  endfunction

  function automatic void apply_reg(input logic [CIDX_W-1:0] idx,
                                    input logic [COORD_W-1:0] val);
    case (idx)
      REG_P0_X: ctrl_x[0] = val;
      REG_P0_Y: ctrl_y[0] = val;
      REG_P1_X: ctrl_x[1] = val;
      REG_P1_Y: ctrl_y[1] = val;
      REG_P2_X: ctrl_x[2] = val;
      REG_P2_Y: ctrl_y[2] = val;
      REG_P3_X: ctrl_x[3] = val;
      REG_P3_Y: ctrl_y[3] = val;
      default: ;  // unused index, dropped
    endcase
  endfunction

  // append one expected pixel at the tail of the queue
  function automatic void queue_expect(input pixel_t px);
    pending_px = {pending_px, px};
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // cfg valid is left high so back-to-back writes never drop it within one step
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  // one t word; the expected pixel is queued once the word is taken
  task automatic send_t(input logic [T_IN_W-1:0] t, input logic typed,
                        input pixel_t typed_px);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      t_param_i  <= T_IN_W'($urandom);   // payload is don't-care while idle
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    t_param_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    queue_expect(typed ? typed_px : predict_pixel(t));
  endtask

  // stop offering words and wait until every expected pixel is out
  task automatic drain_pipeline();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_px.size() != 0);
  endtask

  // corners and random spots, so the extremes keep showing up
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return COORD_MAX;
      default: return COORD_W'($urandom_range(1023));
    endcase
  endfunction

  // new control points, with writes to unused indexes mixed in
  task automatic load_random_curve();
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(3) == 0)
        write_reg(CIDX_W'($urandom_range(8, 255)), COORD_W'($urandom));
      write_reg(REG_ORDER[i], pick_coord());
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly inside [0, 1.0], with the ends and clamped values now and then
  function automatic logic [T_IN_W-1:0] pick_t();
    case ($urandom_range(9))
      0: return '0;
      1: return T_IN_ONE;
      2: return T_IN_W'($urandom_range(131071));
      default: return T_IN_W'($urandom_range(65536));
    endcase
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    pixel_t none;
    none = '0;
    for (int i = 0; i < 4; i++) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; the block has to be empty before any register write
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        if (r == 0 || DIR_ROWS[r-1].kind != ROW_CFG) drain_pipeline();
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
      end else begin
        cfg_valid_i <= 1'b0;
        send_t(DIR_ROWS[r].t, DIR_ROWS[r].typed, DIR_ROWS[r].px);
      end
    end

    // random part: receiver-heavy idling, then sender-heavy, then none at all
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 36; sink_idle_pct = 83; end
        1: begin src_idle_pct = 83; sink_idle_pct = 36; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        load_random_curve();
        // back-pressure test: receiver goes dark while words keep coming
        if (ph == 2 && blk == 0) hold_req = 1'b1;
        for (int n = 0; n < WORDS_PER_BLOCK; n++) send_t(pick_t(), 1'b0, none);
      end
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("bezier_de_casteljau_point test passed");
    end else begin
      $display("bezier_de_casteljau_point test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // random ready, or a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // compare each word leaving the block with the oldest prediction
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_px.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending: x=%0d y=%0d plot=%0b",
                                  pixel_x_o, pixel_y_o, plot_o));
      end else begin
        want = pending_px.pop_front();
        if (pixel_x_o !== want.x)
          report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x_o, want.x));
        if (pixel_y_o !== want.y)
          report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y_o, want.y));
        if (plot_o !== want.plot)
          report_mismatch($sformatf("plot got %0b want %0b", plot_o, want.plot));
      end
    end
  end

  // hang detector: counts cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bezier_de_casteljau_point test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
